### sv/kpd_pkg.sv
// Shared types and codes for the keypad scanner with debounce and event queue.
`timescale 1ns / 1ps
`default_nettype none

package kpd_pkg;

  // Fixed field widths of the item and result ports
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned LEVELS_W = 8;
  localparam int unsigned KEY_W    = 6;
  localparam int unsigned ROW_OUT_W = 3;
  localparam int unsigned THR_W    = 4;
  localparam int unsigned EVENT_W  = KEY_W + 1;

  localparam logic [THR_W-1:0] THR_RESET = 4'd3;

  // Action codes carried by an input transaction
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POP   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_POP,
    OP_QUERY,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_DRAIN,
    ST_WAIT,
    ST_RESULT
  } back_state_e;

  // Classified command handed from front to back
  typedef struct packed {
    op_e                 op;
    logic [LEVELS_W-1:0] levels;
    logic [KEY_W-1:0]    key;
    logic                key_ok;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    logic [ROW_OUT_W-1:0] drive_row;
    logic                 ev_valid;
    logic [KEY_W-1:0]     ev_key;
    logic                 ev_pressed;
    logic                 key_state;
  } res_t;

endpackage

`default_nettype wire

### sv/kpd_front.sv
// Front end: accepts input transactions, classifies them and queues commands.
`timescale 1ns / 1ps
`default_nettype none

module kpd_front
  import kpd_pkg::*;
#(
  parameter int unsigned NUM_LINES = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [ACTION_W-1:0] action_i,
  input  wire logic [LEVELS_W-1:0] line_levels_i,
  input  wire logic [KEY_W-1:0]    key_index_i,
  output logic                     cmd_valid_o,
  output cmd_t                     cmd_o,
  input  wire logic                cmd_ready_i
);

  localparam int unsigned NUM_KEYS = NUM_LINES * NUM_LINES;

  cmd_t       cmd_in;
  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  // Decode the action and range-check the query key
  always_comb begin
    cmd_in.levels = line_levels_i;
    cmd_in.key    = key_index_i;
    cmd_in.key_ok = ({1'b0, key_index_i} < 7'(NUM_KEYS));
    unique case (action_i)
      ACT_TICK:  cmd_in.op = OP_TICK;
      ACT_POP:   cmd_in.op = OP_POP;
      ACT_QUERY: cmd_in.op = OP_QUERY;
      default:   cmd_in.op = OP_NOP;
    endcase
  end

  assign full        = cnt_q[1];
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = cmd_valid_o && cmd_ready_i;

  // Two-entry command queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_q <= !wr_ptr_q;
      if (rd_en) rd_ptr_q <= !rd_ptr_q;
      priority if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 2'd1;
      end else begin
        cnt_q <= cnt_q;
      end
    end
  end

endmodule

`default_nettype wire

### sv/kpd_back.sv
// Back end: debounce sequencer, key state memory, event ring and result register.
`timescale 1ns / 1ps
`default_nettype none

module kpd_back
  import kpd_pkg::*;
#(
  parameter int unsigned NUM_LINES   = 8,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  input  wire cmd_t             cmd_i,
  output logic                  cmd_ready_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [THR_W-1:0] cfg_data_i,
  output logic                  res_valid_o,
  output res_t                  res_o,
  input  wire logic             res_pop_i
);

  localparam int unsigned NUM_KEYS = NUM_LINES * NUM_LINES;
  localparam int unsigned KEY_AW   = $clog2(NUM_KEYS);
  localparam int unsigned ROW_W    = $clog2(NUM_LINES);
  localparam int unsigned QAW      = $clog2(QUEUE_DEPTH);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(NUM_LINES - 1);
  localparam logic [QAW-1:0]   Q_LAST   = QAW'(QUEUE_DEPTH - 1);

  back_state_e state_q, state_d;

  logic [THR_W-1:0]     thr_q;
  logic [ROW_W-1:0]     row_q, row_d, col_q, col_d;
  op_e                  op_q, op_d;
  logic [NUM_LINES-1:0] lv_q, lv_d;
  logic                 qok_q, qok_d, hit_q, hit_d;
  logic                 p_vld_q, p_vld_d, p_down_q, p_down_d;
  logic [KEY_AW-1:0]    p_key_q, p_key_d, tick_key;
  logic [QAW-1:0]       head_q, head_d, tail_q, tail_d, head_nx, tail_nx;

  // Key state memory: {stable, counter} per key, valid bits model the reset
  logic [THR_W:0]       ks_mem [NUM_KEYS];
  logic [NUM_KEYS-1:0]  key_vld_q;
  logic [THR_W:0]       ks_rdata_q, ks_wdata;
  logic                 ks_rvld_q, ks_re, ks_we;
  logic [KEY_AW-1:0]    ks_raddr;

  // Event ring: {pressed, key}
  logic [EVENT_W-1:0]   ev_mem [QUEUE_DEPTH];
  logic [EVENT_W-1:0]   ev_rdata_q, ev_wdata;
  logic                 ev_re, ev_we;

  // Debounce datapath
  logic [THR_W-1:0]     thr_eff, cur_cnt, new_cnt;
  logic [THR_W:0]       cnt_inc;
  logic                 cur_st, new_st;

  res_t                 res_d, out_q;
  logic                 out_vld_q, res_load;

  assign cfg_ready_o = 1'b1;
  assign tick_key    = KEY_AW'(int'(row_q) * NUM_LINES + int'(col_q));
  assign head_nx     = (head_q == Q_LAST) ? '0 : head_q + QAW'(1);
  assign tail_nx     = (tail_q == Q_LAST) ? '0 : tail_q + QAW'(1);

  // Counter update for the key whose read data just arrived
  always_comb begin
    thr_eff = (thr_q == '0) ? THR_W'(1) : thr_q;
    cur_cnt = ks_rvld_q ? ks_rdata_q[THR_W-1:0] : '0;
    cur_st  = ks_rvld_q && ks_rdata_q[THR_W];
    cnt_inc = {1'b0, cur_cnt} + (THR_W+1)'(1);
    if (p_down_q) begin
      new_cnt = (cnt_inc >= {1'b0, thr_eff}) ? thr_eff : cnt_inc[THR_W-1:0];
    end else begin
      new_cnt = (cur_cnt != '0) ? cur_cnt - THR_W'(1) : '0;
    end
    new_st = cur_st;
    ev_we  = 1'b0;
    priority if (!cur_st && (new_cnt >= thr_eff)) begin
      new_st = 1'b1;
      ev_we  = p_vld_q;
    end else if (cur_st && (new_cnt == '0)) begin
      new_st = 1'b0;
      ev_we  = p_vld_q;
    end else begin
      new_st = cur_st;
      ev_we  = 1'b0;
    end
    ks_we    = p_vld_q;
    ks_wdata = {new_st, new_cnt};
    ev_wdata = {new_st, KEY_W'(p_key_q)};
  end

  // Sequencer: next state, memory ports and queue pointers
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    op_d        = op_q;
    lv_d        = lv_q;
    qok_d       = qok_q;
    hit_d       = hit_q;
    p_vld_d     = 1'b0;
    p_key_d     = p_key_q;
    p_down_d    = p_down_q;
    head_d      = head_q;
    tail_d      = tail_q;
    ks_re       = 1'b0;
    ks_raddr    = tick_key;
    ev_re       = 1'b0;
    cmd_ready_o = 1'b0;
    res_load    = 1'b0;

    res_d.drive_row  = ROW_OUT_W'(row_q);
    res_d.ev_valid   = (op_q == OP_POP) && hit_q;
    res_d.ev_key     = res_d.ev_valid ? ev_rdata_q[KEY_W-1:0] : '0;
    res_d.ev_pressed = res_d.ev_valid && ev_rdata_q[KEY_W];
    res_d.key_state  = (op_q == OP_QUERY) && qok_q && ks_rvld_q && ks_rdata_q[THR_W];

    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          op_d  = cmd_i.op;
          lv_d  = cmd_i.levels[NUM_LINES-1:0];
          qok_d = cmd_i.key_ok;
          unique case (cmd_i.op)
            OP_TICK: begin
              col_d   = '0;
              state_d = ST_TICK;
            end
            OP_POP: begin
              hit_d = (tail_q != head_q);
              if (tail_q != head_q) begin
                ev_re  = 1'b1;
                tail_d = tail_nx;
              end
              state_d = ST_WAIT;
            end
            OP_QUERY: begin
              ks_re    = cmd_i.key_ok;
              ks_raddr = cmd_i.key[KEY_AW-1:0];
              state_d  = ST_WAIT;
            end
            default: state_d = ST_RESULT;
          endcase
        end
      end
      ST_TICK: begin
        ks_re    = 1'b1;
        p_vld_d  = (col_q != row_q);
        p_key_d  = tick_key;
        p_down_d = !lv_q[col_q];
        if (col_q == ROW_LAST) begin
          state_d = ST_DRAIN;
        end else begin
          col_d = col_q + ROW_W'(1);
        end
      end
      ST_DRAIN: begin
        row_d   = (row_q == ROW_LAST) ? '0 : row_q + ROW_W'(1);
        state_d = ST_RESULT;
      end
      ST_WAIT: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_vld_q || res_pop_i) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Event push, dropping the oldest entry when the ring is full
    if (ev_we) begin
      head_d = head_nx;
      if (head_nx == tail_q) begin
        tail_d = tail_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= THR_RESET;
      row_q     <= '0;
      col_q     <= '0;
      op_q      <= OP_NOP;
      qok_q     <= 1'b0;
      hit_q     <= 1'b0;
      p_vld_q   <= 1'b0;
      head_q    <= '0;
      tail_q    <= '0;
      key_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) thr_q <= cfg_data_i;
      row_q   <= row_d;
      col_q   <= col_d;
      op_q    <= op_d;
      qok_q   <= qok_d;
      hit_q   <= hit_d;
      p_vld_q <= p_vld_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      if (ks_we) key_vld_q[p_key_q] <= 1'b1;
      priority if (res_load) begin
        out_vld_q <= 1'b1;
      end else if (res_pop_i) begin
        out_vld_q <= 1'b0;
      end else begin
        out_vld_q <= out_vld_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    lv_d_hold: begin
      lv_q     <= lv_d;
      p_key_q  <= p_key_d;
      p_down_q <= p_down_d;
    end
    if (res_load) out_q <= res_d;
  end

  // Key state memory ports
  always_ff @(posedge clk_i) begin
    if (ks_we) ks_mem[p_key_q] <= ks_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (ks_re) begin
      ks_rdata_q <= ks_mem[ks_raddr];
      ks_rvld_q  <= key_vld_q[ks_raddr];
    end
  end

  // Event ring ports
  always_ff @(posedge clk_i) begin
    if (ev_we) ev_mem[head_q] <= ev_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (ev_re) ev_rdata_q <= ev_mem[tail_q];
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

  // A push always leaves at least one event queued
  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_we |=> (head_q != tail_q))
    else $error("event ring empty right after a push");

  // Write-back and next read of the tick never hit the same key
  a_ks_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ks_we && ks_re) |-> (p_key_q != ks_raddr))
    else $error("key memory read and write collide");

  // Counter write-back only happens while a tick is in flight
  a_wb_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld_q |-> ((state_q == ST_TICK) || (state_q == ST_DRAIN)))
    else $error("key write-back outside a tick");

  // Scan row stays inside the line count
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= ROW_LAST)
    else $error("scan row out of range");

endmodule

`default_nettype wire

### sv/keypad_scan_debounce_events.sv
// Top level of the keypad scanner with per-key debounce and event queue.
`timescale 1ns / 1ps
`default_nettype none

// Keypad scanner with debounce. Each input transaction is a scan tick, an event
// pop or a key query, and each produces exactly one result transaction carrying
// the row to drive next. A tick walks the columns of the current row through the
// key state memory one per cycle and then advances the row in a drain step;
// pop and query go through a memory read, a result build and a result load.
// Commands sit in a two-entry queue in front of the sequencer and the result
// sits in an output register, so push and pop may stall independently. The
// event ring keeps QUEUE_DEPTH - 1 events and drops the oldest when full. The
// debounce threshold is written through the cfg port, which is always ready;
// write it only while the block is idle. A threshold of zero acts as one.
module keypad_scan_debounce_events
  import kpd_pkg::*;
#(
  parameter int unsigned NUM_LINES   = 8,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [ACTION_W-1:0]  action_i,
  input  wire logic [LEVELS_W-1:0]  line_levels_i,
  input  wire logic [KEY_W-1:0]     key_index_i,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [ROW_OUT_W-1:0]      drive_row_o,
  output logic                      event_valid_o,
  output logic [KEY_W-1:0]          event_key_o,
  output logic                      event_pressed_o,
  output logic                      key_state_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [THR_W-1:0]     cfg_data_i
);

  logic cmd_valid, cmd_ready, res_valid;
  cmd_t cmd;
  res_t res;

  kpd_front #(
    .NUM_LINES (NUM_LINES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .line_levels_i (line_levels_i),
    .key_index_i   (key_index_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_ready_i   (cmd_ready)
  );

  kpd_back #(
    .NUM_LINES   (NUM_LINES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  // Result transaction fields
  assign empty           = !res_valid;
  assign drive_row_o     = res.drive_row;
  assign event_valid_o   = res.ev_valid;
  assign event_key_o     = res.ev_key;
  assign event_pressed_o = res.ev_pressed;
  assign key_state_o     = res.key_state;

endmodule

`default_nettype wire
